@@ hdl/waveform_sample_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Waveform sample generator assertion macros
// Implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH
`define WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH

// same-cycle implication
`define WSG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSG_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wsg_pkg.sv @@
// ----------------------------------------------------------------------------
// wsg_pkg
// Shape codes, register indexes, configuration struct and the Q1.15 sine table
// shared by the waveform sample generator modules.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int DAC_W       = 12;
    localparam int DAC_MAX     = 4095;
    localparam int SINE_STEPS  = 100;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        SHAPE_TRIANGLE = 2'd0,
        SHAPE_RECT     = 2'd1,
        SHAPE_SINE     = 2'd2
    } shape_t;

    localparam logic [1:0] REG_SHAPE = 2'd0;
    localparam logic [1:0] REG_LOW   = 2'd1;
    localparam logic [1:0] REG_HIGH  = 2'd2;

    localparam logic [DAC_W-1:0] LOW_RESET  = 12'd0;
    localparam logic [DAC_W-1:0] HIGH_RESET = 12'd4095;

    typedef struct packed {
        shape_t            shape;
        logic [DAC_W-1:0]  low;
        logic [DAC_W-1:0]  high;
    } wave_cfg_t;

    localparam logic [15:0] SINE_QUARTER [0:25] = '{
        16'd0,     16'd2057,  16'd4107,  16'd6140,  16'd8149,  16'd10126,
        16'd12062, 16'd13952, 16'd15786, 16'd17557, 16'd19260, 16'd20886,
        16'd22431, 16'd23886, 16'd25247, 16'd26509, 16'd27666, 16'd28714,
        16'd29648, 16'd30466, 16'd31163, 16'd31738, 16'd32187, 16'd32509,
        16'd32702, 16'd32767
    };

    function automatic logic signed [15:0] sine_q15(input logic [6:0] k);
        logic [6:0]          j;
        logic                neg;
        logic signed [15:0]  v;
        if (k <= 7'd25)
        begin
            j   = k;
            neg = 1'b0;
        end
        else if (k <= 7'd50)
        begin
            j   = 7'd50 - k;
            neg = 1'b0;
        end
        else if (k <= 7'd75)
        begin
            j   = k - 7'd50;
            neg = 1'b1;
        end
        else
        begin
            j   = 7'd100 - k;
            neg = 1'b1;
        end
        v = $signed(SINE_QUARTER[j[4:0]]);
        return neg ? -v : v;
    endfunction

endpackage

@@ hdl/wsg_queue.sv @@
// ----------------------------------------------------------------------------
// wsg_queue
// Small register queue between the position front end and the sample pipeline.
// ----------------------------------------------------------------------------
module wsg_queue
    import wsg_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (!push && pop)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/wsg_front.sv @@
// ----------------------------------------------------------------------------
// wsg_front
// Accepts sample requests, applies restart and tracks buffer position and
// sine phase; each request becomes one queue entry {last, phase, position}.
// ----------------------------------------------------------------------------
module wsg_front
    import wsg_pkg::*;
#(
    parameter int BUFFER_LENGTH = 100,
    parameter int SINE_PERIOD   = 100,
    parameter int PW            = 7,
    parameter int PHW           = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  restart,
    output logic                  req_ready,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [PW+PHW:0]       q_wdata
);

    logic [PW-1:0]  pos_reg, pos_next, pos_cur;
    logic [PHW-1:0] ph_reg,  ph_next,  ph_cur;
    logic           last;

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        pos_cur = restart ? '0 : pos_reg;
        ph_cur  = restart ? '0 : ph_reg;
        last    = (pos_cur == PW'(BUFFER_LENGTH - 1));
        q_wdata = {last, ph_cur, pos_cur};
        pos_next = pos_reg;
        ph_next  = ph_reg;
        if (q_push)
        begin
            if (last)
            begin
                pos_next = '0;
                ph_next  = '0;
            end
            else
            begin
                pos_next = PW'(pos_cur + 1'b1);
                ph_next  = (ph_cur == PHW'(SINE_PERIOD - 1)) ? '0 : PHW'(ph_cur + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ph_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            ph_reg  <= ph_next;
        end
    end

endmodule

@@ hdl/wsg_back.sv @@
// ----------------------------------------------------------------------------
// wsg_back
// Sample pipeline: turns queued positions into clamped DAC codes for the
// selected shape, four stages plus an output register, stalled as one.
// ----------------------------------------------------------------------------
module wsg_back
    import wsg_pkg::*;
#(
    parameter int BUFFER_LENGTH = 100,
    parameter int SINE_PERIOD   = 100,
    parameter int PW            = 7,
    parameter int PHW           = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wave_cfg_t         cfg,
    input  logic              q_empty,
    input  logic [PW+PHW:0]   q_rdata,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DAC_W-1:0]  sample_value,
    output logic              pass_end
);

    localparam int H   = BUFFER_LENGTH / 2;
    localparam int LN  = $clog2(BUFFER_LENGTH);
    localparam int DS  = DAC_W + LN;
    localparam int DM  = ((1 << DS) + BUFFER_LENGTH - 1) / BUFFER_LENGTH;
    localparam int DMW = DAC_W + 2;
    localparam int QPW = DAC_W + DMW;
    localparam int LP  = $clog2(SINE_PERIOD);
    localparam int XW  = $clog2(SINE_PERIOD * SINE_STEPS);
    localparam int KS  = XW + LP;
    localparam int KM  = ((1 << KS) + SINE_PERIOD - 1) / SINE_PERIOD;
    localparam int KMW = XW + 2;
    localparam int KPW = XW + KMW;
    localparam int STW = DAC_W + 2;
    localparam int TPW = STW + PW + 1;
    localparam int SW  = TPW + 2;
    localparam int APW = DAC_W + 16;

    logic [PW-1:0]           pos0;
    logic [PHW-1:0]          ph0;
    logic                    last0;
    logic signed [DAC_W:0]   d;
    logic [DAC_W-1:0]        dmag;
    logic signed [DAC_W-1:0] amp;
    logic                    en;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                    v1_next, v2_next, v3_next, v4_next, out_valid_next;

    logic [PW-1:0]           s1_pos_reg, s2_pos_reg;
    logic                    s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [XW-1:0]           s1_x_reg;
    logic [QPW-1:0]          s1_qprod_reg;
    logic                    s1_dneg_reg;
    logic [6:0]              s2_k_reg;
    logic signed [STW-1:0]   s2_step_reg;
    logic signed [15:0]      s3_t_reg;
    logic signed [TPW-1:0]   s3_tprod_reg;
    logic                    s3_first_reg;
    logic signed [DAC_W-1:0] s3_amp_reg, s4_amp_reg;
    logic signed [APW-1:0]   s4_sprod_reg;
    logic signed [SW-1:0]    s4_tri_reg;
    logic [DAC_W-1:0]        s4_rect_reg;
    logic [DAC_W-1:0]        sample_reg;
    logic                    last_reg;

    logic [KPW-1:0]          kprod;
    logic [DAC_W-1:0]        q;
    logic [DAC_W:0]          step_mag;
    logic [PW-1:0]           ioff;
    logic signed [SW-1:0]    lo_s, hi_s, sine_s, pick;
    logic [DAC_W-1:0]        clamped;

    assign {last0, ph0, pos0} = q_rdata;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;
    assign pass_end     = last_reg;

    always_comb
    begin
        d    = $signed({1'b0, cfg.high}) - $signed({1'b0, cfg.low});
        dmag = d[DAC_W] ? DAC_W'(-d) : DAC_W'(d);
        amp  = DAC_W'((d + $signed({{DAC_W{1'b0}}, d[DAC_W]})) >>> 1);
    end

    always_comb
    begin
        kprod    = KPW'(s1_x_reg) * KPW'(KM);
        q        = DAC_W'(s1_qprod_reg >> DS);
        step_mag = {q, 1'b0};
        ioff     = (s2_pos_reg < PW'(H)) ? s2_pos_reg : PW'(s2_pos_reg - PW'(H));
    end

    always_comb
    begin
        lo_s   = SW'($signed({1'b0, cfg.low}));
        hi_s   = SW'($signed({1'b0, cfg.high}));
        sine_s = SW'(s4_sprod_reg >>> 15) + lo_s + SW'(s4_amp_reg);
        case (cfg.shape)
            SHAPE_TRIANGLE: pick = s4_tri_reg;
            SHAPE_RECT:     pick = SW'($signed({1'b0, s4_rect_reg}));
            SHAPE_SINE:     pick = sine_s;
            default:        pick = lo_s;
        endcase
        if (pick < 0)
        begin
            clamped = '0;
        end
        else if (pick > $signed(SW'(DAC_MAX)))
        begin
            clamped = DAC_W'(DAC_MAX);
        end
        else
        begin
            clamped = pick[DAC_W-1:0];
        end
    end

    always_comb
    begin
        v1_next        = en ? !q_empty      : v1_reg;
        v2_next        = en ? v1_reg        : v2_reg;
        v3_next        = en ? v2_reg        : v3_reg;
        v4_next        = en ? v3_reg        : v4_reg;
        out_valid_next = en ? v4_reg        : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pos_reg   <= pos0;
            s1_last_reg  <= last0;
            s1_x_reg     <= XW'(ph0) * XW'(SINE_STEPS);
            s1_qprod_reg <= QPW'(dmag) * QPW'(DM);
            s1_dneg_reg  <= d[DAC_W];

            s2_pos_reg   <= s1_pos_reg;
            s2_last_reg  <= s1_last_reg;
            s2_k_reg     <= 7'(kprod >> KS);
            s2_step_reg  <= s1_dneg_reg ? -$signed({1'b0, step_mag})
                                        :  $signed({1'b0, step_mag});

            s3_t_reg     <= sine_q15(s2_k_reg);
            s3_tprod_reg <= TPW'(s2_step_reg * $signed({1'b0, ioff}));
            s3_first_reg <= (s2_pos_reg < PW'(H));
            s3_amp_reg   <= amp;
            s3_last_reg  <= s2_last_reg;

            s4_sprod_reg <= APW'(s3_amp_reg * s3_t_reg);
            s4_tri_reg   <= s3_first_reg ? lo_s + SW'(s3_tprod_reg)
                                         : hi_s - SW'(s3_tprod_reg);
            s4_rect_reg  <= s3_first_reg ? cfg.high : cfg.low;
            s4_amp_reg   <= s3_amp_reg;
            s4_last_reg  <= s3_last_reg;

            sample_reg   <= clamped;
            last_reg     <= s4_last_reg;
        end
    end

endmodule

@@ hdl/waveform_sample_generator.sv @@
// ----------------------------------------------------------------------------
// waveform_sample_generator
// Triangle, rectangle and sine DAC samples over a wrapping buffer position.
//
//   channel   | dir | handshake           | payload
//   s_*       | in  | s_tvalid / s_tready | s_tdata[0] restart
//   m_*       | out | m_tvalid / m_tready | m_tdata[11:0] sample_value, m_tlast pass_end
//   cfg_*     | in  | cfg_we              | cfg_addr register index, cfg_wdata value
//
// One sample per cycle sustained while m_tready stays high.
// The four-stage sample pipeline and output register stall together on m_tready;
// the four-entry queue accepts requests meanwhile until it is full.
// rst_n clears position, phase, queue and valid flags and loads register defaults.
// ----------------------------------------------------------------------------
`include "waveform_sample_generator_macros.svh"

module waveform_sample_generator
    import wsg_pkg::*;
#(
    parameter int BUFFER_LENGTH = 100,
    parameter int SINE_PERIOD   = 100
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] restart
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [11:0] sample_value
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [DAC_W-1:0]  cfg_wdata
);

    localparam int PW  = $clog2(BUFFER_LENGTH);
    localparam int PHW = $clog2(SINE_PERIOD);
    localparam int QW  = PW + PHW + 1;

    shape_t           shape_reg;
    logic [DAC_W-1:0] low_reg;
    logic [DAC_W-1:0] high_reg;
    wave_cfg_t        cfg;

    logic             q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]    q_wdata, q_rdata;
    logic [DAC_W-1:0] sample_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_TRIANGLE;
            low_reg   <= LOW_RESET;
            high_reg  <= HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SHAPE: shape_reg <= shape_t'(cfg_wdata[1:0]);
                REG_LOW:   low_reg   <= cfg_wdata;
                REG_HIGH:  high_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign cfg = '{shape: shape_reg, low: low_reg, high: high_reg};

    wsg_front #(
        .BUFFER_LENGTH (BUFFER_LENGTH),
        .SINE_PERIOD   (SINE_PERIOD),
        .PW            (PW),
        .PHW           (PHW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .restart   (s_tdata[0]),
        .req_ready (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    wsg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    wsg_back #(
        .BUFFER_LENGTH (BUFFER_LENGTH),
        .SINE_PERIOD   (SINE_PERIOD),
        .PW            (PW),
        .PHW           (PHW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .sample_value (sample_value),
        .pass_end     (m_tlast)
    );

    assign m_tdata = {4'b0000, sample_value};

    `WSG_ASSERT_NXT(a_push_lands, s_tvalid && s_tready, !q_empty,
                    "accepted request did not reach the queue")
    `WSG_ASSERT_IMP(a_queue_flags, q_full || q_empty, !(q_full && q_empty),
                    "queue full and empty at once")
    `WSG_ASSERT_IMP(a_full_blocks, q_full, !s_tready,
                    "request taken while queue full")
    `WSG_ASSERT_IMP(a_stall_holds, m_tvalid && !m_tready, !q_pop,
                    "queue drained while output stalled")

endmodule
